[src/tccw_pkg.sv]
// Shared types and constants for the text console cell writer.
// Item and result beats, controller command and status, register codes.
package tccw_pkg;

  localparam int CHAR_W     = 8;
  localparam int ATTR_W     = 8;
  localparam int READ_ROW_W = 5;
  localparam int READ_COL_W = 7;
  localparam int OFFSET_W   = 11;
  localparam int CELL_W     = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {ATTR_RESET, BLANK_CHAR};

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  typedef struct packed {
    logic                  func;
    logic [CHAR_W-1:0]     char_code;
    logic [READ_ROW_W-1:0] read_row;
    logic [READ_COL_W-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;
    logic [READ_ROW_W-1:0] cursor_row;
    logic [READ_COL_W-1:0] cursor_col;
    logic [OFFSET_W-1:0]   cursor_offset;
  } result_t;

  typedef struct packed {
    logic latch_item;
    logic exec;
    logic clear_step;
    logic blank_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic blank_last;
    logic scroll;
    logic result_free;
  } sts_t;

endpackage

[src/tccw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/tccw_ctrl.sv]
// Controller state machine of the text console cell writer.
// Depends on tccw_pkg for command and status types.
module tccw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  tccw_pkg::sts_t sts,
  output tccw_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.scroll ? S_SCROLL : S_DONE;
      end
      S_SCROLL: begin
        cmd.blank_step = 1'b1;
        if (sts.blank_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.result_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[src/tccw_dp.sv]
// Datapath of the text console cell writer: cursor, ring base, sweep counters,
// cell memory and result register. Depends on tccw_pkg and tccw_ram.
module tccw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tccw_pkg::cmd_t                  cmd,
  output tccw_pkg::sts_t                  sts,
  input  tccw_pkg::item_t                 item_in,
  input  logic [tccw_pkg::ATTR_W-1:0]     attr,
  output tccw_pkg::result_t               result,
  output logic                            result_valid,
  input  logic                            result_stall
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RR_W   = ROW_W + tccw_pkg::READ_ROW_W;
  localparam int RC_W   = COL_W + tccw_pkg::READ_COL_W;

  tccw_pkg::item_t item;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] top;
  logic [ROW_W-1:0] sweep_row;
  logic [COL_W-1:0] sweep_col;

  logic is_put, is_nl, col_last, row_last, advance_row, read_ok, sweeping, sweep_col_last;
  logic [RR_W-1:0] rrow_ext;
  logic [RC_W-1:0] rcol_ext;
  logic [ROW_W-1:0] lrow, prow, arow, top_wrap;
  logic [COL_W-1:0] lcol, acol;
  logic [ROW_W:0] row_sum;
  logic [ADDR_W-1:0] addr, offset;
  logic we, re;
  logic [tccw_pkg::CELL_W-1:0] wdata, rdata;

  assign is_put      = (item.func == tccw_pkg::FUNC_PUT);
  assign is_nl       = (item.char_code == tccw_pkg::NEWLINE_CODE);
  assign col_last    = (cur_col == COL_W'(COLUMNS - 1));
  assign row_last    = (cur_row == ROW_W'(ROWS - 1));
  assign advance_row = is_nl || col_last;
  assign top_wrap    = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;

  assign rrow_ext = {{ROW_W{1'b0}}, item.read_row};
  assign rcol_ext = {{COL_W{1'b0}}, item.read_col};
  assign read_ok  = (rrow_ext < RR_W'(ROWS)) && (rcol_ext < RC_W'(COLUMNS));

  assign lrow    = is_put ? cur_row : rrow_ext[ROW_W-1:0];
  assign lcol    = is_put ? cur_col : rcol_ext[COL_W-1:0];
  assign row_sum = {1'b0, lrow} + {1'b0, top};
  assign prow    = (row_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W+1)'(ROWS))
                                                 : row_sum[ROW_W-1:0];

  assign sweeping       = cmd.clear_step || cmd.blank_step;
  assign sweep_col_last = (sweep_col == COL_W'(COLUMNS - 1));
  assign arow = sweeping ? sweep_row : prow;
  assign acol = sweeping ? sweep_col : lcol;
  assign addr = ADDR_W'(ADDR_W'(arow) * ADDR_W'(COLUMNS)) + ADDR_W'(acol);

  assign we    = sweeping || (cmd.exec && is_put && !is_nl);
  assign wdata = sweeping ? tccw_pkg::BLANK_CELL : {attr, item.char_code};
  assign re    = cmd.exec && !is_put && read_ok;

  tccw_ram #(
    .WIDTH(tccw_pkg::CELL_W),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata(wdata),
    .re   (re),
    .raddr(addr),
    .rdata(rdata)
  );

  assign sts.scroll      = is_put && advance_row && row_last;
  assign sts.blank_last  = sweep_col_last;
  assign sts.clear_last  = sweep_col_last && (sweep_row == ROW_W'(ROWS - 1));
  assign sts.result_free = !result_valid || !result_stall;

  assign offset = ADDR_W'(ADDR_W'(cur_row) * ADDR_W'(COLUMNS)) + ADDR_W'(cur_col);

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item <= item_in;
    end
    if (cmd.load_result) begin
      if ((item.func == tccw_pkg::FUNC_READ) && read_ok) begin
        result.cell_char <= rdata[tccw_pkg::CHAR_W-1:0];
        result.cell_attr <= rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
      end else begin
        result.cell_char <= '0;
        result.cell_attr <= '0;
      end
      result.cursor_row    <= tccw_pkg::READ_ROW_W'(cur_row);
      result.cursor_col    <= tccw_pkg::READ_COL_W'(cur_col);
      result.cursor_offset <= tccw_pkg::OFFSET_W'(offset);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row      <= '0;
      cur_col      <= '0;
      top          <= '0;
      sweep_row    <= '0;
      sweep_col    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.exec && is_put) begin
        if (advance_row) begin
          cur_col <= '0;
          if (row_last) begin
            // move the ring base, then blank the old top row
            top       <= top_wrap;
            sweep_row <= top;
            sweep_col <= '0;
          end else begin
            cur_row <= cur_row + 1'b1;
          end
        end else begin
          cur_col <= cur_col + 1'b1;
        end
      end
      if (sweeping) begin
        if (sweep_col_last) begin
          sweep_col <= '0;
          if (cmd.clear_step) begin
            sweep_row <= (sweep_row == ROW_W'(ROWS - 1)) ? '0 : sweep_row + 1'b1;
          end
        end else begin
          sweep_col <= sweep_col + 1'b1;
        end
      end
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[src/text_console_cell_writer.sv]
// Text console cell writer: top level with APB register and port assertions.
// Depends on tccw_pkg, tccw_ctrl, tccw_dp (which holds tccw_ram).
//
// After reset the block blanks its cell memory one cell a cycle, with
// item_stall high; register writes are taken meanwhile. Then items are
// taken one at a time, each going from acceptance to its result beat
// through the controller sequence around the cell memory (latch, memory
// access, result load). Scrolling moves a ring base over the rows and
// blanks the new bottom row, so a put that scrolls also waits while that
// row is blanked. A result waiting on result_stall does not keep the next
// item from being accepted.
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  tccw_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output tccw_pkg::result_t                   result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tccw_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tccw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tccw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;
  logic [tccw_pkg::ATTR_W-1:0] text_attribute;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == tccw_pkg::REG_TEXT_ATTRIBUTE);
  assign prdata  = reg_hit ? tccw_pkg::APB_DATA_W'(text_attribute) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tccw_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      text_attribute <= pwdata[tccw_pkg::ATTR_W-1:0];
    end
  end

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tccw_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .item_in     (item),
    .attr        (text_attribute),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while previous item in flight");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ROWS <= 32 && COLUMNS <= 128) |->
      (result.cursor_offset ==
       tccw_pkg::OFFSET_W'(32'(result.cursor_row) * COLUMNS + 32'(result.cursor_col))))
    else $error("cursor offset inconsistent with row and column");

endmodule
